/* src/modular_inverse_defines.svh */
// Assertion macros for the modular inverse block.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef MODULAR_INVERSE_DEFINES_SVH
`define MODULAR_INVERSE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define MINV_ASSERT(name, prop, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("modular_inverse: assertion failed");
// Property must never hold at a clock edge outside reset.
`define MINV_ASSERT_NEVER(name, prop, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("modular_inverse: forbidden condition seen");
`else
`define MINV_ASSERT(name, prop, clk, rst_n)
`define MINV_ASSERT_NEVER(name, prop, clk, rst_n)
`endif

`endif

/* src/minv_pkg.sv */
// Shared types and constants for the modular inverse block.
// No dependencies; imported by minv_alu and modular_inverse.
package minv_pkg;

  // Width of the operand and result ports.
  localparam int FIELD_W = 64;

  typedef enum logic {
    ALU_SUB,
    ALU_ADD
  } alu_op_e;

endpackage

/* src/minv_alu.sv */
// Shared add/subtract unit of the modular inverse block.
// Depends on minv_pkg for the operation code.
module minv_alu import minv_pkg::*; #(
  parameter int W = 64
) (
  input  alu_op_e        op_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [W-1:0]   res_o,
  output logic           borrow_o
);

  logic [W:0] sum;

  always_comb begin
    case (op_i)
      ALU_ADD: sum = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: sum = {1'b0, a_i} - {1'b0, b_i};
      default: sum = {1'b0, a_i} - {1'b0, b_i};
    endcase
  end

  assign res_o    = sum[W-1:0];
  // Set on subtract when b exceeds a.
  assign borrow_o = (op_i == ALU_SUB) ? sum[W] : 1'b0;

endmodule

/* src/modular_inverse.sv */
// A zero modulus is answered straight from idle. Otherwise each Euclid step runs check,
// align (shift the divisor up), subtract and add per quotient bit (shifting back down),
// then swap; finish then tests the gcd and, for a negative coefficient, folds it into range.
// One transaction at a time; busy_o stays high until the result is out.
// Results show for one cycle on done_o and cannot be stalled by the receiver.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops done_o.
`include "modular_inverse_defines.svh"

module modular_inverse import minv_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [FIELD_W-1:0] value_a_i,
  input  logic [FIELD_W-1:0] modulus_i,
  output logic               busy_o,
  output logic               done_o,
  output logic               exists_o,
  output logic [FIELD_W-1:0] inverse_o
);

  // Datapath width: only the low min(WIDTH, FIELD_W) bits of each field take part.
  localparam int DW = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;
  localparam int CW = $clog2(DW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ALIGN,
    S_SUB,
    S_ADD,
    S_SWAP,
    S_FIN,
    S_NEG
  } state_e;

  state_e state_q, state_d;

  // Euclid registers: remainders r0/r1, coefficient magnitudes u0/u1 with
  // signs n0/n1 (set means negative), and the modulus kept for the final fixup.
  logic [DW-1:0] r0_q, r0_d, r1_q, r1_d;
  logic [DW-1:0] u0_q, u0_d, u1_q, u1_d;
  logic          n0_q, n0_d, n1_q, n1_d;
  logic [DW-1:0] m_q, m_d;

  // Divider registers: running remainder, aligned divisor, matching shifted
  // coefficient, and the accumulated new coefficient u0 + q*u1.
  logic [DW-1:0] rem_q, rem_d, d_q, d_d, ud_q, ud_d, acc_q, acc_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic               done_q, done_d, exists_q, exists_d;
  logic [FIELD_W-1:0] inv_q, inv_d;

  logic [DW-1:0] a_in, m_in;
  logic [DW-1:0] t_red;

  alu_op_e       alu_op;
  logic [DW-1:0] alu_a, alu_b, alu_res;
  logic          alu_borrow;

  assign a_in = value_a_i[DW-1:0];
  assign m_in = modulus_i[DW-1:0];

  // The coefficient never exceeds the modulus, so one compare reduces it.
  assign t_red = (u0_q == m_q) ? '0 : u0_q;

  minv_alu #(.W(DW)) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .borrow_o(alu_borrow)
  );

  // Steer the shared unit by state.
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = rem_q;
    alu_b  = d_q;
    case (state_q)
      S_ALIGN: begin
        alu_b = {d_q[DW-2:0], 1'b0};
      end
      S_ADD: begin
        alu_op = ALU_ADD;
        alu_a  = acc_q;
        alu_b  = ud_q;
      end
      S_NEG: begin
        alu_a = m_q;
        alu_b = t_red;
      end
      default: begin
        alu_op = ALU_SUB;
      end
    endcase
  end

  // Sequencer: hold everything by default, advance per state.
  always_comb begin
    state_d  = state_q;
    r0_d     = r0_q;
    r1_d     = r1_q;
    u0_d     = u0_q;
    u1_d     = u1_q;
    n0_d     = n0_q;
    n1_d     = n1_q;
    m_d      = m_q;
    rem_d    = rem_q;
    d_d      = d_q;
    ud_d     = ud_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    exists_d = exists_q;
    inv_d    = inv_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (m_in == '0) begin
            // Zero modulus: answer at once.
            done_d   = 1'b1;
            exists_d = 1'b0;
            inv_d    = '0;
          end else begin
            // Start from (a, m) with coefficients (1, 0); the first step then
            // yields (m, a mod m) with coefficients (0, +1).
            r0_d    = a_in;
            r1_d    = m_in;
            m_d     = m_in;
            u0_d    = DW'(1);
            u1_d    = '0;
            n0_d    = 1'b0;
            n1_d    = 1'b1;
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (r1_q == '0) begin
          state_d = S_FIN;
        end else begin
          rem_d   = r0_q;
          d_d     = r1_q;
          ud_d    = u1_q;
          acc_d   = u0_q;
          cnt_d   = '0;
          state_d = S_ALIGN;
        end
      end
      S_ALIGN: begin
        // Shift the divisor up while twice it still fits under the remainder.
        if (!d_q[DW-1] && !alu_borrow) begin
          d_d   = {d_q[DW-2:0], 1'b0};
          ud_d  = {ud_q[DW-2:0], 1'b0};
          cnt_d = cnt_q + CW'(1);
        end else begin
          state_d = S_SUB;
        end
      end
      S_SUB: begin
        if (!alu_borrow) begin
          // Quotient bit set: keep the difference, then add the coefficient.
          rem_d   = alu_res;
          state_d = S_ADD;
        end else if (cnt_q == '0) begin
          state_d = S_SWAP;
        end else begin
          d_d   = {1'b0, d_q[DW-1:1]};
          ud_d  = {1'b0, ud_q[DW-1:1]};
          cnt_d = cnt_q - CW'(1);
        end
      end
      S_ADD: begin
        acc_d = alu_res;
        if (cnt_q == '0) begin
          state_d = S_SWAP;
        end else begin
          d_d     = {1'b0, d_q[DW-1:1]};
          ud_d    = {1'b0, ud_q[DW-1:1]};
          cnt_d   = cnt_q - CW'(1);
          state_d = S_SUB;
        end
      end
      S_SWAP: begin
        r0_d    = r1_q;
        r1_d    = rem_q;
        u0_d    = u1_q;
        u1_d    = acc_q;
        n0_d    = n1_q;
        n1_d    = !n1_q;
        state_d = S_CHECK;
      end
      S_FIN: begin
        if (r0_q != DW'(1)) begin
          done_d   = 1'b1;
          exists_d = 1'b0;
          inv_d    = '0;
          state_d  = S_IDLE;
        end else if (n0_q && (t_red != '0)) begin
          state_d = S_NEG;
        end else begin
          done_d   = 1'b1;
          exists_d = 1'b1;
          inv_d    = FIELD_W'(t_red);
          state_d  = S_IDLE;
        end
      end
      S_NEG: begin
        // Negative coefficient: fold into range as m - t.
        done_d   = 1'b1;
        exists_d = 1'b1;
        inv_d    = FIELD_W'(alu_res);
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer state and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      exists_q <= 1'b0;
      inv_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      exists_q <= exists_d;
      inv_q    <= inv_d;
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk_i) begin
    r0_q  <= r0_d;
    r1_q  <= r1_d;
    u0_q  <= u0_d;
    u1_q  <= u1_d;
    n0_q  <= n0_d;
    n1_q  <= n1_d;
    m_q   <= m_d;
    rem_q <= rem_d;
    d_q   <= d_d;
    ud_q  <= ud_d;
    acc_q <= acc_d;
  end

  assign busy_o    = (state_q != S_IDLE);
  assign done_o    = done_q;
  assign exists_o  = exists_q;
  assign inverse_o = inv_q;

  // The sequencer is back in idle whenever a result is shown.
  `MINV_ASSERT(a_done_idle, done_o |-> !busy_o, clk_i, rst_ni)
  // No inverse value leaks out with a not-exists result.
  `MINV_ASSERT(a_zero_when_none, (done_o && !exists_o) |-> (inverse_o == '0), clk_i, rst_ni)
  // A reported inverse lies below the modulus.
  `MINV_ASSERT(a_inv_range, (done_o && exists_o) |-> (inverse_o < FIELD_W'(m_q)), clk_i, rst_ni)
  // The divide loop never runs with a zero divisor.
  `MINV_ASSERT_NEVER(a_div_zero, ((state_q == S_SUB) || (state_q == S_ALIGN)) && (d_q == '0),
                     clk_i, rst_ni)

endmodule
